// ===== rtl/mkrs_pkg.sv =====
// Package: record types, sequencer states and the sort-order compare for the record sorter.
`default_nettype none
package mkrs_pkg;

	typedef struct packed {
		logic [15:0] record_id;
		logic [6:0]  first_mark;
		logic [6:0]  second_mark;
		logic [3:0]  group_no;
		logic [7:0]  section_code;
		logic [7:0]  name_tag;
		logic        last_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_id;
		logic [6:0]  out_first_mark;
		logic [6:0]  out_second_mark;
		logic [3:0]  out_group_no;
		logic [7:0]  out_section_code;
		logic [7:0]  out_name_tag;
		logic        overflow;
		logic        last_out;
	} out_item_t;

	// one stored record, without the framing bit
	typedef struct packed {
		logic [15:0] id;
		logic [6:0]  fm;
		logic [6:0]  sm;
		logic [3:0]  grp;
		logic [7:0]  sec;
		logic [7:0]  tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_PUT,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	// true when a must be placed strictly ahead of b
	function automatic logic goes_before(rec_t a, rec_t b);
		logic r;
		if (a.sm != b.sm) begin
			r = (a.sm > b.sm);
		end else if (a.fm != b.fm) begin
			r = (a.fm > b.fm);
		end else begin
			r = (a.id < b.id);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mkrs_mem.sv =====
// Record store: one write port, one read port with registered read data.
`default_nettype none
module mkrs_mem import mkrs_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire rec_t          wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output rec_t               rdata
);

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/multi_key_record_sorter_core.sv =====
// Top level: record sorter with insertion into a single-port-read record memory.
`default_nettype none
// Usage
//   Load a set of records, one request each: drive in_item and raise start;
//   the request is taken at a rising edge with start high and busy low.
//   Each record is inserted into the memory in sorted order (second mark
//   descending, then first mark descending, then id ascending; equal records
//   keep arrival order). Insertion walks down from the end of the store with
//   a read and a compare per entry it moves; a record into an empty store
//   is written at the head at once, one into a full store is dropped, and
//   the walk is bounded by the one memory read port and its registered read
//   data.
//   When a request carries last_in, the store is then read out in order, one
//   record per cycle, on out_item with strobe high for exactly one cycle each;
//   the final record has last_out set, and busy drops in the cycle after it.
//   The receiver cannot stall, so results are never held back.
//   Records arriving with the store full are dropped and every result of that
//   set shows overflow. After read-out the count and overflow flag clear.
//   Reset clears the count, flag and sequencer; memory content is left as is.
module multi_key_record_sorter_core import mkrs_pkg::*; #(
	parameter int MAX_RECORDS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire in_item_t  in_item,
	output logic           strobe,
	output out_item_t      out_item
);

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECORDS);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          drop_q;
	rec_t          rec_q;
	logic          last_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] e_q;
	logic          valid_s1, lastf_s1, ovf_s1;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	rec_t          wdata, rdata, in_rec;
	logic          accept, ahead;

	assign in_rec = '{id: in_item.record_id, fm: in_item.first_mark,
		sm: in_item.second_mark, grp: in_item.group_no,
		sec: in_item.section_code, tag: in_item.name_tag};
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign ahead  = goes_before(rec_q, rdata);

	mkrs_mem #(.DEPTH(MAX_RECORDS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = j_q[AW-1:0];
		wdata   = rec_q;
		re      = 1'b0;
		raddr   = e_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cnt_q == CNT_MAX) begin
						state_d = in_item.last_in ? ST_EMIT : ST_IDLE;
					end else if (cnt_q == '0) begin
						// empty store: place directly at the head
						we      = 1'b1;
						waddr   = '0;
						wdata   = in_rec;
						state_d = in_item.last_in ? ST_EMIT : ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				re      = 1'b1;
				raddr   = AW'(j_q - CNT_ONE);
				state_d = ST_CMP;
			end
			ST_CMP: begin
				we = 1'b1;
				if (ahead) begin
					// shift the stored record one place down
					wdata   = rdata;
					state_d = (j_q == CNT_ONE) ? ST_PUT : ST_READ;
				end else begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_PUT: begin
				we      = 1'b1;
				waddr   = '0;
				state_d = last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				re = 1'b1;
				if (e_q + CNT_ONE == cnt_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// count, overflow flag, indexes and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			j_q      <= '0;
			e_q      <= '0;
			last_q   <= 1'b0;
			valid_s1 <= 1'b0;
			lastf_s1 <= 1'b0;
			ovf_s1   <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			lastf_s1 <= 1'b0;
			if (state_q != ST_EMIT) begin
				e_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= in_item.last_in;
						j_q    <= cnt_q;
						if (cnt_q == CNT_MAX) begin
							drop_q <= 1'b1;
						end else if (cnt_q == '0) begin
							cnt_q <= CNT_ONE;
						end
					end
				end
				ST_CMP: begin
					if (ahead) begin
						j_q <= j_q - CNT_ONE;
					end else begin
						cnt_q <= cnt_q + CNT_ONE;
					end
				end
				ST_PUT: begin
					cnt_q <= cnt_q + CNT_ONE;
				end
				ST_EMIT: begin
					valid_s1 <= 1'b1;
					lastf_s1 <= (e_q + CNT_ONE == cnt_q);
					ovf_s1   <= drop_q;
					e_q      <= e_q + CNT_ONE;
				end
				ST_DRAIN: begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// hold the arriving record for the insertion walk
	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q <= in_rec;
		end
	end

	assign strobe = valid_s1;
	assign out_item = '{out_id: rdata.id, out_first_mark: rdata.fm,
		out_second_mark: rdata.sm, out_group_no: rdata.grp,
		out_section_code: rdata.sec, out_name_tag: rdata.tag,
		overflow: ovf_s1, last_out: lastf_s1};

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX) else $error("record count above capacity");
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (state_q == ST_EMIT || state_q == ST_DRAIN))
		else $error("result strobe outside read-out");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && out_item.last_out) |=> !strobe)
		else $error("result after final record");
	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (strobe && out_item.last_out))
		else $error("read-out ended without final record");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/multi_key_record_sorter_core_tb.sv =====
// Testbench for the record sorter: random and directed record sets checked against a sorted model.
`default_nettype none
module multi_key_record_sorter_core_tb;
	import mkrs_pkg::*;

	localparam int CAP = 64;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  in_item;
	logic      strobe;
	out_item_t out_item;

	multi_key_record_sorter_core #(.MAX_RECORDS(CAP)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .strobe(strobe), .out_item(out_item)
	);

	// sender idle odds per phase, percent; the sender sends no new request while hold_drain is set
	in_item_t  pending_requests[$];
	out_item_t expected_records[$];
	int        idle_pct;
	bit        hold_drain;
	int        errors;
	int        records_sent;
	int        records_seen;
	int        sets_sent;
	int        overflow_sets;

	// sorted shadow of the store
	rec_t      sorted_store[$];
	bit        store_dropped;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// true when a belongs strictly ahead of b in output order
	function automatic bit ranks_ahead(rec_t a, rec_t b);
		if (a.sm != b.sm) return a.sm > b.sm;
		if (a.fm != b.fm) return a.fm > b.fm;
		return a.id < b.id;
	endfunction

	// insert one request into the shadow store and queue the set's results on last_in
	task automatic predict_sorted(in_item_t req);
		rec_t      r;
		int        pos;
		out_item_t o;
		r.id  = req.record_id;
		r.fm  = req.first_mark;
		r.sm  = req.second_mark;
		r.grp = req.group_no;
		r.sec = req.section_code;
		r.tag = req.name_tag;
		if (sorted_store.size() < CAP) begin
			pos = sorted_store.size();
			for (int i = 0; i < sorted_store.size(); i++) begin
				if (ranks_ahead(r, sorted_store[i])) begin
					pos = i;
					break;
				end
			end
			sorted_store.insert(pos, r);
		end else begin
			store_dropped = 1'b1;
		end
		if (req.last_in) begin
			sets_sent++;
			if (store_dropped) overflow_sets++;
			foreach (sorted_store[i]) begin
				o.out_id           = sorted_store[i].id;
				o.out_first_mark   = sorted_store[i].fm;
				o.out_second_mark  = sorted_store[i].sm;
				o.out_group_no     = sorted_store[i].grp;
				o.out_section_code = sorted_store[i].sec;
				o.out_name_tag     = sorted_store[i].tag;
				o.overflow         = store_dropped;
				o.last_out         = (i == sorted_store.size() - 1);
				expected_records.push_back(o);
			end
			sorted_store.delete();
			store_dropped = 1'b0;
		end
	endtask

	// Driver: present the next request, hold it until taken, idle at random between requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			in_item <= '0;
		end else begin
			if (start && !busy) begin
				predict_sorted(in_item);
				records_sent++;
			end
			if (start && busy) begin
				// hold the request until it is accepted
			end else if (pending_requests.size() != 0 && !hold_drain
					&& $urandom_range(99) >= idle_pct) begin
				in_item <= pending_requests.pop_front();
				start   <= 1'b1;
			end else begin
				start   <= 1'b0;
			end
		end
	end

	// Monitor: every strobe is one result, compared against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && strobe) begin
			records_seen++;
			if (expected_records.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, out_item);
			end else begin
				want = expected_records.pop_front();
				if (want !== out_item) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, want, out_item);
				end
			end
		end
	end

	// random mark, biased toward ties and the edges of the 7-bit range
	function automatic logic [6:0] pick_mark();
		case ($urandom_range(5))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'd127;
			3: return 7'($urandom_range(48, 52));
			default: return 7'($urandom);
		endcase
	endfunction

	function automatic in_item_t make_record(bit last);
		in_item_t r;
		r.record_id    = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
		r.first_mark   = pick_mark();
		r.second_mark  = pick_mark();
		r.group_no     = 4'($urandom);
		r.section_code = 8'($urandom);
		r.name_tag     = 8'($urandom);
		r.last_in      = last;
		return r;
	endfunction

	// queue one set of n records, the final one flagged last
	task automatic queue_set(int n);
		for (int i = 0; i < n; i++) pending_requests.push_back(make_record(i == n - 1));
	endtask

	// wait until the driver has sent everything and all results are back
	task automatic drain();
		while (pending_requests.size() != 0 || start || busy || expected_records.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		in_item_t r;
		int       n;
		errors        = 0;
		records_sent  = 0;
		records_seen  = 0;
		sets_sent     = 0;
		overflow_sets = 0;
		store_dropped = 1'b0;
		idle_pct      = 0;
		hold_drain    = 1'b0;
		arst_n        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single-record set at both field extremes
		r = '0;
		r.last_in = 1'b1;
		pending_requests.push_back(r);
		r = '1;
		pending_requests.push_back(r);
		// full ties keep arrival order, payload tells them apart
		for (int i = 0; i < 4; i++) begin
			r = '0;
			r.record_id    = 16'h1234;
			r.first_mark   = 7'd100;
			r.second_mark  = 7'd100;
			r.section_code = 8'(i);
			r.name_tag     = 8'(8'hf0 + i);
			r.last_in      = (i == 3);
			pending_requests.push_back(r);
		end
		// tie-breaks: second mark, then first mark, then id ascending
		r = '0;
		r.second_mark = 7'd5;  r.first_mark = 7'd9; r.record_id = 16'd3;
		pending_requests.push_back(r);
		r.second_mark = 7'd5;  r.first_mark = 7'd9; r.record_id = 16'd1;
		pending_requests.push_back(r);
		r.second_mark = 7'd5;  r.first_mark = 7'd90; r.record_id = 16'hffff;
		pending_requests.push_back(r);
		r.second_mark = 7'd127; r.first_mark = 7'd0; r.record_id = 16'd0;
		r.last_in = 1'b1;
		pending_requests.push_back(r);
		drain();

		// full store with extra records dropped, the last one among them
		queue_set(CAP + 3);
		drain();

		// random sets across idling phases; small sets mostly, a few around capacity
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 63 : (ph == 2) ? 0 : 23;
			n = 0;
			while (n < 75) begin
				int sz;
				sz = ($urandom_range(9) == 0) ? $urandom_range(CAP - 2, CAP + 2)
					: $urandom_range(1, 8);
				queue_set(sz);
				n += sz;
			end
			// finish the phase at its own idle odds before the next one starts
			drain();
			// after the second phase, pause the sender a while with nothing in flight
			if (ph == 1) begin
				hold_drain = 1'b1;
				repeat (20) @(posedge clk);
				hold_drain = 1'b0;
			end
		end
		drain();
		repeat (10) @(posedge clk);

		$display("Covered %0d records in %0d sets (%0d with overflow), %0d results checked.",
			records_sent, sets_sent, overflow_sets, records_seen);
		if (errors == 0) begin
			$display("** multi_key_record_sorter_core: PASSED **");
		end else begin
			$display("** multi_key_record_sorter_core: FAILED **");
		end
		$finish;
	end

	// watchdog: generous bound on the slowest correct run
	initial begin
		#5000000;
		$display("Timeout waiting for results.");
		$display("** multi_key_record_sorter_core: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
